@@ src/absq_pkg.sv @@
// Shared types and constants of the absmax int8 offset quantizer.
// No dependencies; imported by every module of the block.
package absq_pkg;

    // Command carried in the input tuser field
    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_MEASURE = 2'd1,
        CMD_QUANT   = 2'd2
    } t_cmd;

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAS,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } t_state;

    // Quotient of 254*|sample| / peak fits 9 bits when |sample| < 2*peak
    localparam int QUOT_BITS = 9;
    localparam int CODE_BITS = 8;
    localparam int CMD_BITS  = 2;

    // Divider result: 2*ratio = quot + rem/peak
    typedef struct packed {
        logic [QUOT_BITS-1:0] quot;
        logic                 rem_nz;
    } t_div_res;

    // Everything the output stage needs to form one code word
    typedef struct packed {
        logic     neg;
        logic     zero_peak;
        logic     over;      // |sample| >= 2*peak, clamped unless the peak is zero
        t_div_res div;
    } t_rnd_in;

endpackage

@@ src/absq_div.sv @@
// Shift-subtract divider producing one quotient bit per cycle.
// Depends on absq_pkg (QUOT_BITS, t_div_res).
module absq_div #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [SAMPLE_BITS+6:0]  i_dividend,
    input  logic [SAMPLE_BITS-2:0]  i_divisor,
    output logic                    o_done,
    output absq_pkg::t_div_res      o_res
);
    import absq_pkg::*;

    localparam int XW    = SAMPLE_BITS + 7;
    localparam int RW    = SAMPLE_BITS;
    localparam int CNT_W = $clog2(QUOT_BITS + 1);

    logic                 r_run;
    logic [CNT_W-1:0]     r_cnt;
    logic [RW-1:0]        r_rem;
    logic [QUOT_BITS-1:0] r_low;   // dividend bits still to shift in
    logic [QUOT_BITS-1:0] r_quot;  // quotient bits shifted in
    logic [RW-1:0]        n_trial;
    logic [RW-1:0]        n_sub;
    logic                 n_ge;

    // One restoring step: bring down the next dividend bit, try the subtract
    always_comb begin
        n_trial = {r_rem[RW-2:0], r_low[QUOT_BITS-1]};
        n_sub   = n_trial - {1'b0, i_divisor};
        n_ge    = n_trial >= {1'b0, i_divisor};
    end

    // Sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= CNT_W'(QUOT_BITS);
        end else if (r_run) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_run <= 1'b0;
            end
        end
    end

    // Datapath shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= RW'(i_dividend[XW-1:QUOT_BITS]);
            r_low  <= i_dividend[QUOT_BITS-1:0];
            r_quot <= '0;
        end else if (r_run) begin
            r_rem  <= n_ge ? n_sub : n_trial;
            r_low  <= {r_low[QUOT_BITS-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_BITS-2:0], n_ge};
        end
    end

    // Last step lands at this edge; result registers are valid after it
    assign o_done       = r_run && (r_cnt == CNT_W'(1));
    assign o_res.quot   = r_quot;
    assign o_res.rem_nz = (r_rem != '0);

endmodule

@@ src/absq_out.sv @@
// Rounding, clamping and output register stage of the quantizer.
// Depends on absq_pkg (t_rnd_in, CODE_BITS, QUOT_BITS).
module absq_out (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  absq_pkg::t_rnd_in       i_rnd,
    output logic                    o_ready,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [7:0]              m_axis_tdata,   // [7:0] code
    output logic                    m_axis_tuser    // [0] clipped
);
    import absq_pkg::*;

    logic                 r_valid;
    logic [CODE_BITS-1:0] r_code;
    logic                 r_clip;
    logic [QUOT_BITS:0]   n_pos_sum;
    logic [QUOT_BITS:0]   n_neg_sum;
    logic [QUOT_BITS-1:0] n_pos_mag;
    logic [QUOT_BITS-1:0] n_neg_mag;
    logic [CODE_BITS-1:0] n_code;
    logic                 n_clip;

    // Positive: (a+1)>>1. Negative: -((a + rem_nz)>>1), i.e. floor of ratio + 1/2
    always_comb begin
        n_pos_sum = {1'b0, i_rnd.div.quot} + (QUOT_BITS+1)'(1);
        n_neg_sum = {1'b0, i_rnd.div.quot} + (QUOT_BITS+1)'(i_rnd.div.rem_nz);
        n_pos_mag = n_pos_sum[QUOT_BITS:1];
        n_neg_mag = n_neg_sum[QUOT_BITS:1];
        n_code    = 8'd128;
        n_clip    = 1'b0;
        if (i_rnd.zero_peak) begin
            n_code = 8'd128;
            n_clip = 1'b0;
        end else if (i_rnd.over) begin
            n_code = i_rnd.neg ? 8'd0 : 8'd255;
            n_clip = 1'b1;
        end else if (!i_rnd.neg) begin
            if (n_pos_mag > QUOT_BITS'(127)) begin
                n_code = 8'd255;
                n_clip = 1'b1;
            end else begin
                n_code = CODE_BITS'(QUOT_BITS'(128) + n_pos_mag);
            end
        end else begin
            if (n_neg_mag > QUOT_BITS'(128)) begin
                n_code = 8'd0;
                n_clip = 1'b1;
            end else begin
                n_code = CODE_BITS'(QUOT_BITS'(128) - n_neg_mag);
            end
        end
    end

    // Output word holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_code <= n_code;
            r_clip <= n_clip;
        end
    end

    assign o_ready       = !r_valid || m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_code;
    assign m_axis_tuser  = r_clip;

endmodule

@@ src/absmax_int8_offset_quantizer.sv @@
// Absmax int8 offset quantizer: clear, measure and quantize words in, offset-128 codes out.
// Quantize: an accepted word passes prepare, the 9-step shift-subtract divider (one quotient
// bit per cycle) and finish, which waits until the output register can take the code. Peak
// zero or sample >= 2*peak skips the divider. Words are taken only in idle, one at a time.
// Output register lets the next word enter while a code waits to be taken.
// Synchronous active-low reset clears the peak, the sequencer and the output valid.
module absmax_int8_offset_quantizer #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,  // [SAMPLE_BITS-1:0] sample
    input  logic [absq_pkg::CMD_BITS-1:0]         s_axis_tuser,  // [1:0] cmd
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [7:0]                            m_axis_tdata,  // [7:0] code
    output logic                                  m_axis_tuser   // [0] clipped
);
    import absq_pkg::*;

    localparam int N  = SAMPLE_BITS;
    localparam int XW = SAMPLE_BITS + 7;
    localparam int EW = SAMPLE_BITS + 8;

    t_state          r_state;
    t_state          n_state;
    logic [N-2:0]    r_peak;
    logic [N-1:0]    r_mag;     // |sample|, holds 2^(N-1) for the most negative
    logic            r_neg;
    logic [XW-1:0]   r_x;       // 254*|sample|
    logic            r_zero;
    logic            r_over;

    logic            in_acc;
    logic            meas_upd;
    logic            div_start;
    logic            out_load;
    logic            out_ready;
    logic            div_done;
    t_div_res        div_res;
    t_rnd_in         rnd;

    logic [N-1:0]    n_smp;
    logic [EW-1:0]   n_sx;
    logic [EW-1:0]   n_x;
    logic [N-2:0]    n_sat;
    logic            n_zero;
    logic            n_over;

    // Input word: magnitude and 254*|sample| with one subtract each
    always_comb begin
        n_smp = s_axis_tdata[N-1:0];
        n_sx  = {{8{n_smp[N-1]}}, n_smp};
        n_x   = n_smp[N-1] ? ((n_sx << 1) - (n_sx << 8)) : ((n_sx << 8) - (n_sx << 1));
    end

    // Measured magnitude saturates to the peak width
    assign n_sat  = r_mag[N-1] ? '1 : r_mag[N-2:0];
    assign n_zero = (r_peak == '0);
    assign n_over = ({1'b0, r_mag} >= {1'b0, r_peak, 1'b0});

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && s_axis_tuser == CMD_MEASURE) begin
                    n_state = ST_MEAS;
                end else if (in_acc && s_axis_tuser == CMD_QUANT) begin
                    n_state = ST_PREP;
                end
            end
            ST_MEAS: n_state = ST_IDLE;
            ST_PREP: n_state = (n_zero || n_over) ? ST_FIN : ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        meas_upd      = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_MEAS: meas_upd      = 1'b1;
            ST_PREP: div_start     = !(n_zero || n_over);
            ST_FIN:  out_load      = out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Peak register: clear on command, raise on measure
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else if (in_acc && s_axis_tuser == CMD_CLEAR) begin
            r_peak <= '0;
        end else if (meas_upd && n_sat > r_peak) begin
            r_peak <= n_sat;
        end
    end

    // Captured sample and quantize flags
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_neg <= n_smp[N-1];
            r_mag <= n_smp[N-1] ? (N'(0) - n_smp) : n_smp;
            r_x   <= n_x[XW-1:0];
        end
        if (r_state == ST_PREP) begin
            r_zero <= n_zero;
            r_over <= n_over;
        end
    end

    absq_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_x),
        .i_divisor  (r_peak),
        .o_done     (div_done),
        .o_res      (div_res)
    );

    assign rnd.neg       = r_neg;
    assign rnd.zero_peak = r_zero;
    assign rnd.over      = r_over;
    assign rnd.div       = div_res;

    absq_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (out_load),
        .i_rnd         (rnd),
        .o_ready       (out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

`ifndef SYNTH
    // A measure never lowers the peak
    a_meas_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        meas_upd |=> r_peak >= $past(r_peak))
        else $error("peak decreased on measure");

    // A clear word leaves the peak at zero
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser == CMD_CLEAR) |=> r_peak == '0)
        else $error("peak not cleared");

    // The divider only runs against a nonzero peak
    a_div_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> r_peak != '0)
        else $error("divider started with zero peak");

    // Divider completion moves the sequencer to finish
    a_div_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && div_done) |=> r_state == ST_FIN)
        else $error("divider done not followed by finish");

    // An output load always produces a valid word next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> m_axis_tvalid)
        else $error("loaded word not presented");
`endif

endmodule
